@@ rtl/core/dust_sample_moving_average_core_assert.svh @@
// Assertion macros for the dust sample moving average core.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef DUST_SAMPLE_MOVING_AVERAGE_CORE_ASSERT_SVH
`define DUST_SAMPLE_MOVING_AVERAGE_CORE_ASSERT_SVH

// Same-cycle implication.
`define DSMA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DSMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/dsma_pkg.sv @@
// Shared types and constants for the dust sample moving average core.
// No dependencies.
package dsma_pkg;

  localparam int unsigned DENS_W = 13;
  localparam int unsigned RAW_W  = 13;
  localparam int unsigned DIV_W  = 5;
  localparam int unsigned CNT_OUT_W = 4;

  typedef logic [DENS_W-1:0]        dens_t;
  typedef logic signed [RAW_W-1:0]  raw_t;
  typedef logic [DIV_W-1:0]         divisor_t;
  typedef logic [CNT_OUT_W-1:0]     fill_t;

  localparam logic [1:0] REG_GAIN    = 2'd0;
  localparam logic [1:0] REG_OFFSET  = 2'd1;
  localparam logic [1:0] REG_CEILING = 2'd2;

  localparam logic [15:0] GAIN_RST    = 16'd6602;
  localparam logic [15:0] OFFSET_RST  = 16'd19200;
  localparam dens_t       CEILING_RST = 13'd8000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULT,
    ST_CLAMP,
    ST_PUSH,
    ST_DIVIDE
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ rtl/core/dsma_cell.sv @@
// One window entry of the density shift chain.
// Depends on dsma_pkg.
module dsma_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  dsma_pkg::dens_t prev_i,
  output dsma_pkg::dens_t entry_o
);
  import dsma_pkg::*;

  dens_t entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (shift_i) begin
      entry_q <= prev_i;
    end
  end

  assign entry_o = entry_q;

endmodule

@@ rtl/core/dsma_divider.sv @@
// Restoring divider, one quotient bit per cycle, for the window mean.
// Depends on dsma_pkg.
module dsma_divider #(
  parameter int unsigned SUM_W = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [SUM_W-1:0]   dividend_i,
  input  dsma_pkg::divisor_t divisor_i,
  output dsma_pkg::dens_t    quot_o,
  output dsma_pkg::div_stat_t stat_o
);
  import dsma_pkg::*;

  localparam int unsigned CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] dq_q;
  divisor_t         rem_q;
  divisor_t         div_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             fits;

  assign trial = {rem_q, dq_q[SUM_W-1]};
  assign fits  = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(SUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      dq_q  <= {dq_q[SUM_W-2:0], fits};
      rem_q <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    end
  end

  assign quot_o      = dq_q[DENS_W-1:0];
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

@@ rtl/core/dust_sample_moving_average_core.sv @@
// Dust sample moving average core, top level.
// Depends on dsma_pkg, dsma_cell, dsma_divider and the assertion header.
//
// Input channel: raw_sample_i with in_valid_i / in_stall_o. One signed ADC
// reading per transfer. Negative readings convert to density 0.
// Output channel: sample_density_o, average_density_o, fill_count_o with
// out_valid_o / out_stall_i. One result per input transfer, in order.
// Configuration: APB-style port; gain at 0x0, offset at 0x4, ceiling at 0x8.
// Write only while the block is idle.
// Each item passes the multiply, clamp and push steps and then the
// bit-serial divide by the fill count. One item is in work at a time;
// the core takes the next one only in idle, once the result has been
// loaded into the output register.
// A finished result sits in the output register; the next input is taken
// while it waits. A result only stalls the core when the next one is done
// and the receiver still stalls.
// Reset clears the density window, fill count, running total and registers
// to their defaults; the block is ready as soon as reset releases.
module dust_sample_moving_average_core #(
  parameter int unsigned WINDOW_DEPTH = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dsma_pkg::raw_t     raw_sample_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dsma_pkg::dens_t    sample_density_o,
  output dsma_pkg::dens_t    average_density_o,
  output dsma_pkg::fill_t    fill_count_o
);
  import dsma_pkg::*;

  localparam int unsigned SUM_W  = $clog2(WINDOW_DEPTH * 8191 + 1);
  localparam int unsigned SLOT_W = $clog2(WINDOW_DEPTH);

  state_e state_q, state_d;

  logic [15:0] gain_q;
  logic [15:0] offset_q;
  dens_t       ceiling_q;
  logic [1:0]  reg_idx;
  logic        cfg_wr;

  raw_t        raw_q;
  logic [27:0] prod_q;
  logic        neg_q;
  dens_t       dens_q;
  logic [19:0] scaled;
  logic [19:0] excess;
  dens_t       dens_d;

  dens_t       tap [WINDOW_DEPTH];
  logic        shift;

  logic [SUM_W-1:0]  total_q, total_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              full_q, full_d;
  divisor_t          count_q, count_d;

  dens_t       quot;
  div_stat_t   div_stat;
  logic        div_start;

  logic        out_valid_q;
  dens_t       out_dens_q;
  dens_t       out_avg_q;
  fill_t       out_fill_q;
  logic        out_free;
  logic        out_load;
  logic        in_xfer;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q    <= GAIN_RST;
      offset_q  <= OFFSET_RST;
      ceiling_q <= CEILING_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_GAIN:    gain_q    <= pwdata[15:0];
        REG_OFFSET:  offset_q  <= pwdata[15:0];
        REG_CEILING: ceiling_q <= pwdata[DENS_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GAIN:    prdata = {16'd0, gain_q};
      REG_OFFSET:  prdata = {16'd0, offset_q};
      REG_CEILING: prdata = {19'd0, ceiling_q};
      default:     prdata = '0;
    endcase
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d   = state_q;
    shift     = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_MULT;
      end
      ST_MULT:  state_d = ST_CLAMP;
      ST_CLAMP: state_d = ST_PUSH;
      ST_PUSH: begin
        shift     = 1'b1;
        div_start = 1'b1;
        state_d   = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_stat.done && out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Conversion datapath
  assign scaled = prod_q[27:8];
  assign excess = scaled - {4'd0, offset_q};

  always_comb begin
    if (neg_q || (scaled <= {4'd0, offset_q})) begin
      dens_d = '0;
    end else if (excess > {7'd0, ceiling_q}) begin
      dens_d = ceiling_q;
    end else begin
      dens_d = excess[DENS_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) raw_q <= raw_sample_i;
    if (state_q == ST_MULT) begin
      prod_q <= {16'd0, raw_q[11:0]} * {12'd0, gain_q};
      neg_q  <= raw_q[RAW_W-1];
    end
    if (state_q == ST_CLAMP) dens_q <= dens_d;
  end

  // Window chain
  for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
    dsma_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .prev_i  ((k == 0) ? dens_q : tap[(k == 0) ? 0 : k - 1]),
      .entry_o (tap[k])
    );
  end

  assign total_d = total_q - SUM_W'(tap[WINDOW_DEPTH-1]) + SUM_W'(dens_q);
  assign slot_d  = (slot_q == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_q + 1'b1;
  assign full_d  = full_q || (slot_d == '0);
  assign count_d = full_d ? DIV_W'(WINDOW_DEPTH) : DIV_W'(slot_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      slot_q  <= '0;
      full_q  <= 1'b0;
      count_q <= '0;
    end else if (shift) begin
      total_q <= total_d;
      slot_q  <= slot_d;
      full_q  <= full_d;
      count_q <= count_d;
    end
  end

  dsma_divider #(
    .SUM_W (SUM_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (total_d),
    .divisor_i  (count_d),
    .quot_o     (quot),
    .stat_o     (div_stat)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_dens_q <= dens_q;
      out_avg_q  <= quot;
      out_fill_q <= count_q[CNT_OUT_W-1:0];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign sample_density_o  = out_dens_q;
  assign average_density_o = out_avg_q;
  assign fill_count_o      = out_fill_q;

  `include "dust_sample_moving_average_core_assert.svh"

  `DSMA_ASSERT_NEXT(a_accept_starts, in_xfer, state_q == ST_MULT, "idle after transfer")
  `DSMA_ASSERT_NOW(a_divide_live, state_q == ST_DIVIDE, |div_stat, "divider idle in divide")
  `DSMA_ASSERT_NOW(a_empty_total, !full_q && slot_q == '0, total_q == '0, "total not zero")

endmodule

@@ bench/dust_sample_moving_average_core_checker.sv @@
// Checker for the dust sample moving average core: tracks the calibration
// registers from the APB port and mirrors the density window.
// Compares every output transfer in order. Depends on dsma_pkg.
`timescale 1ns / 100ps

module dust_sample_moving_average_core_checker #(
  parameter int unsigned WINDOW_DEPTH = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic            pready,
  input  logic [3:0]      paddr,
  input  logic [31:0]     pwdata,
  input  logic            in_valid_i,
  input  logic            in_stall_o,
  input  dsma_pkg::raw_t  raw_sample_i,
  input  logic            out_valid_o,
  input  logic            out_stall_i,
  input  dsma_pkg::dens_t sample_density_o,
  input  dsma_pkg::dens_t average_density_o,
  input  dsma_pkg::fill_t fill_count_o,
  output int unsigned     mismatch_count_o,
  output int unsigned     backlog_o
);
  import dsma_pkg::*;

  typedef struct packed {
    dens_t sample;
    dens_t average;
    fill_t fill;
  } density_result_t;

  logic [15:0] gain_q;
  logic [15:0] offset_q;
  dens_t       ceiling_q;

  dens_t       window_q [WINDOW_DEPTH];
  int unsigned slot_q;
  logic        full_q;
  int unsigned total_q;

  density_result_t density_queue [$];

  function automatic dens_t calibrate_density(raw_t raw);
    logic [31:0] scaled;
    logic [31:0] excess;
    if (raw < 0) return '0;
    scaled = ({19'd0, raw} * {16'd0, gain_q}) >> 8;
    if (scaled <= {16'd0, offset_q}) return '0;
    excess = scaled - {16'd0, offset_q};
    if (excess > {19'd0, ceiling_q}) excess = {19'd0, ceiling_q};
    return excess[DENS_W-1:0];
  endfunction

  function automatic density_result_t advance_window(raw_t raw);
    density_result_t res;
    dens_t           dens;
    int unsigned     count;
    dens = calibrate_density(raw);
    total_q = total_q - window_q[slot_q] + dens;
    window_q[slot_q] = dens;
    slot_q = (slot_q + 1) % WINDOW_DEPTH;
    if (slot_q == 0) full_q = 1'b1;
    count = full_q ? WINDOW_DEPTH : slot_q;
    res.sample  = dens;
    res.average = dens_t'(total_q / count);
    res.fill    = fill_t'(count);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    density_result_t want;
    if (!rst_ni) begin
      gain_q    = GAIN_RST;
      offset_q  = OFFSET_RST;
      ceiling_q = CEILING_RST;
      for (int i = 0; i < WINDOW_DEPTH; i++) window_q[i] = '0;
      slot_q  = 0;
      full_q  = 1'b0;
      total_q = 0;
      density_queue.delete();
      mismatch_count_o = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (density_queue.size() == 0) begin
          $error("unexpected transfer: sample_density %0d average_density %0d fill_count %0d",
                 sample_density_o, average_density_o, fill_count_o);
          mismatch_count_o++;
        end else begin
          want = density_queue.pop_front();
          if (sample_density_o !== want.sample) begin
            $error("sample_density: expected %0d, got %0d", want.sample, sample_density_o);
            mismatch_count_o++;
          end
          if (average_density_o !== want.average) begin
            $error("average_density: expected %0d, got %0d", want.average, average_density_o);
            mismatch_count_o++;
          end
          if (fill_count_o !== want.fill) begin
            $error("fill_count: expected %0d, got %0d", want.fill, fill_count_o);
            mismatch_count_o++;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_GAIN:    gain_q    = pwdata[15:0];
          REG_OFFSET:  offset_q  = pwdata[15:0];
          REG_CEILING: ceiling_q = pwdata[DENS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) density_queue.push_back(advance_window(raw_sample_i));
    end
    backlog_o = density_queue.size();
  end

endmodule

@@ bench/dust_sample_moving_average_core_tb.sv @@
// Testbench top for the dust sample moving average core: clock, reset,
// register writes, sample and result traffic, watchdog and verdict.
// Depends on dsma_pkg, the core and dust_sample_moving_average_core_checker.
`timescale 1ns / 100ps

module dust_sample_moving_average_core_tb;
  import dsma_pkg::*;

  localparam int unsigned WINDOW_DEPTH  = 8;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_SAMPLES = 200;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam logic [1:0]  REG_UNMAPPED  = 2'd3;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [3:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  raw_t        raw_sample_i = '0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  dens_t       sample_density_o;
  dens_t       average_density_o;
  fill_t       fill_count_o;

  int unsigned mismatch_count;
  int unsigned backlog;
  int unsigned feed_idle_max  = 9;
  int unsigned drain_idle_max = 9;
  int unsigned quiet_cycles   = 0;
  bit          hold_request   = 1'b0;

  always #6 clk_i = ~clk_i;

  dust_sample_moving_average_core #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .raw_sample_i     (raw_sample_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .sample_density_o (sample_density_o),
    .average_density_o(average_density_o),
    .fill_count_o     (fill_count_o)
  );

  dust_sample_moving_average_core_checker #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .raw_sample_i     (raw_sample_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .sample_density_o (sample_density_o),
    .average_density_o(average_density_o),
    .fill_count_o     (fill_count_o),
    .mismatch_count_o (mismatch_count),
    .backlog_o        (backlog)
  );

  task automatic write_register(input logic [1:0] index, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic load_calibration(input logic [15:0] gain, input logic [15:0] offset,
                                  input dens_t ceiling, input bit scramble);
    logic [31:0] junk;
    junk = scramble ? $urandom : 32'd0;
    write_register(REG_GAIN, {junk[31:16], gain});
    write_register(REG_OFFSET, {junk[15:0], offset});
    write_register(REG_CEILING, {junk[31:13], ceiling});
  endtask

  task automatic push_sample(input int value);
    int unsigned gap;
    gap = $urandom_range(0, feed_idle_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    raw_sample_i <= raw_t'(value);
    in_valid_i   <= 1'b1;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (backlog != 0) @(negedge clk_i);
  endtask

  // hold out_stall_i per result, or for a long stretch on request
  initial begin : drain
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      if (hold_request) begin
        gap = LONG_HOLD;
        hold_request = 1'b0;
      end else begin
        gap = $urandom_range(0, drain_idle_max);
      end
      if (gap != 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned phase;
    int unsigned n;
    int unsigned gain_draw;
    int unsigned reach;
    int unsigned offset_draw;
    int unsigned ceiling_draw;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset calibration, window fill and wrap
    push_sample(0);
    push_sample(4095);
    push_sample(-4096);
    push_sample(-1);
    push_sample(1);
    push_sample(744);
    push_sample(745);
    push_sample(1050);
    push_sample(2047);
    push_sample(-2048);

    // unit gain: baseline edge and ceiling clamp
    wait_idle();
    load_calibration(16'd256, 16'd1000, 13'd3000, 1'b0);
    write_register(REG_UNMAPPED, 32'hFFFF_FFFF);
    push_sample(1000);
    push_sample(1001);
    push_sample(3999);
    push_sample(4000);
    push_sample(4001);

    wait_idle();
    load_calibration(16'hFFFF, 16'd0, 13'd8191, 1'b0);
    push_sample(4095);
    push_sample(1);
    push_sample(32);
    push_sample(0);

    wait_idle();
    load_calibration(16'd0, 16'hFFFF, 13'd0, 1'b0);
    push_sample(4095);
    push_sample(-4096);

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: load_calibration(16'hFFFF, 16'd0, 13'd8191, 1'b1);
        1: load_calibration(16'd1, 16'd0, 13'd8000, 1'b1);
        7: load_calibration(GAIN_RST, OFFSET_RST, CEILING_RST, 1'b1);
        default: begin
          gain_draw    = $urandom_range(0, 65535);
          reach        = (4095 * gain_draw) >> 8;
          offset_draw  = $urandom_range(0, (reach < 65535) ? reach : 65535);
          ceiling_draw = ($urandom_range(0, 3) == 0) ? 8191 : $urandom_range(0, 8191);
          load_calibration(gain_draw[15:0], offset_draw[15:0], dens_t'(ceiling_draw), 1'b1);
        end
      endcase
      feed_idle_max  = (phase == 3) ? 0 : 9;
      drain_idle_max = (phase == 3) ? 0 : 9;
      for (n = 0; n < PHASE_SAMPLES; n++) begin
        if (phase == 2 && n == 20) hold_request = 1'b1;
        if ($urandom_range(0, 3) == 0) begin
          push_sample(int'($urandom));
        end else begin
          push_sample($urandom_range(0, 4095));
        end
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/dsma_pkg.sv
rtl/core/dsma_cell.sv
rtl/core/dsma_divider.sv
rtl/core/dust_sample_moving_average_core.sv
bench/dust_sample_moving_average_core_checker.sv
bench/dust_sample_moving_average_core_tb.sv
